// File: rtl/assert_macros.svh
// concurrent assertion helpers, clocked on i_clk, held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_SAME_CYCLE(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT_CYCLE(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME_CYCLE(label, ante, cons)
`define ASSERT_NEXT_CYCLE(label, ante, cons)
`endif

`endif

// File: rtl/ufse_pkg.sv
`timescale 1ns / 1ps

package ufse_pkg;

    localparam int ELEM_W           = 10;
    localparam int RANK_W           = 4;
    localparam int MAX_ELEMENTS_DEF = 1023;
    localparam logic [RANK_W-1:0] RANK_TOP        = 4'd15;
    localparam logic [ELEM_W-1:0] SET_COUNT_RESET = 10'd1023;

    // op field codes
    localparam logic OP_UNION = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // microprogram steps, in program order
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_WALK_A = 3'd2,
        ST_WALK_B = 3'd3,
        ST_DECIDE = 3'd4,
        ST_LINK   = 3'd5,
        ST_BUMP   = 3'd6
    } t_step;

    // jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_CLR_MORE,
        C_IDLE_STAY,
        C_NOT_ROOT,
        C_FINISH,
        C_NO_BUMP
    } t_cond;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_LINK,
        WR_BUMP
    } t_wr;

    typedef struct packed {
        t_cond cond;
        t_step target;
        t_wr   wr;
        logic  load;
        logic  walk;
        logic  root_b;
        logic  emit;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{cond: C_ALWAYS, target: ST_IDLE, wr: WR_NONE,
              load: 1'b0, walk: 1'b0, root_b: 1'b0, emit: 1'b0};
        unique case (step)
            ST_CLEAR: begin
                w.cond   = C_CLR_MORE;
                w.target = ST_CLEAR;
                w.wr     = WR_CLEAR;
            end
            ST_IDLE: begin
                w.cond   = C_IDLE_STAY;
                w.target = ST_IDLE;
                w.load   = 1'b1;
            end
            ST_WALK_A: begin
                w.cond   = C_NOT_ROOT;
                w.target = ST_WALK_A;
                w.walk   = 1'b1;
            end
            ST_WALK_B: begin
                w.cond   = C_NOT_ROOT;
                w.target = ST_WALK_B;
                w.walk   = 1'b1;
                w.root_b = 1'b1;
            end
            ST_DECIDE: begin
                w.cond   = C_FINISH;
                w.target = ST_IDLE;
                w.emit   = 1'b1;
            end
            ST_LINK: begin
                w.cond   = C_NO_BUMP;
                w.target = ST_IDLE;
                w.wr     = WR_LINK;
            end
            ST_BUMP: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
                w.wr     = WR_BUMP;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/union_find_set_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Disjoint-set forest with union by rank over elements 1..set_count. An item
// is taken when start is high and busy is low; an item naming element 0, an
// element above set_count or above MAX_ELEMENTS is dropped on the spot and
// leaves busy low. A valid item walks the parent links of both elements in a
// store with one read and one write port, one link per cycle; busy stays high
// through both walks and the decide step and, on a union of two elements in
// different sets, through the link step and a bump step when the ranks tie. An
// element lies at most 9 links below its root for 1023 elements. A query gives
// one result, shown on o_same_set for exactly one cycle with o_result_valid
// high, in the cycle busy falls; it cannot be held off, so take it then. A
// union gives no result. After reset the store is cleared one entry a cycle,
// all MAX_ELEMENTS + 1 entries (1024 by default), with busy high; set_count may
// be written at any idle time and does not touch the forest.
module union_find_set_engine #(
    parameter int MAX_ELEMENTS = ufse_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [ufse_pkg::ELEM_W-1:0] i_elem_a,
    input  logic [ufse_pkg::ELEM_W-1:0] i_elem_b,
    input  logic                        i_cfg_we,
    input  logic [ufse_pkg::ELEM_W-1:0] i_cfg_wdata,
    output logic                        o_result_valid,
    output logic                        o_same_set
);

    localparam int AW = $clog2(MAX_ELEMENTS + 1);
    localparam int RW = ufse_pkg::RANK_W;
    localparam int MW = AW + RW;

    // store word: {rank, parent}, parent of zero marks a root
    logic [MW-1:0] mem [0:MAX_ELEMENTS];

    ufse_pkg::t_step r_pc, n_pc;
    ufse_pkg::t_ctrl ctrl;

    logic [AW-1:0]              r_clr, n_clr;
    logic [ufse_pkg::ELEM_W-1:0] r_set_count;
    logic [AW-1:0]              r_cur, n_cur;
    logic [AW-1:0]              r_elem_b, n_elem_b;
    logic                       r_op, n_op;
    logic [AW-1:0]              r_root_a, n_root_a;
    logic [AW-1:0]              r_root_b, n_root_b;
    logic [RW-1:0]              r_rank_a, n_rank_a;
    logic [RW-1:0]              r_rank_b, n_rank_b;
    logic [MW-1:0]              r_word;
    logic                       r_valid, n_valid;
    logic                       r_same, n_same;

    logic [AW-1:0] parent;
    logic [RW-1:0] rank;
    logic          is_root;
    logic          is_query;
    logic          a_ok, b_ok, take;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;

    always_comb begin
        ctrl     = ufse_pkg::ucode(r_pc);
        parent   = r_word[AW-1:0];
        rank     = r_word[MW-1:AW];
        is_root  = (parent == '0);
        is_query = (r_op == ufse_pkg::OP_QUERY);

        a_ok = (i_elem_a != '0) && (i_elem_a <= r_set_count)
            && (32'(i_elem_a) <= 32'(MAX_ELEMENTS));
        b_ok = (i_elem_b != '0) && (i_elem_b <= r_set_count)
            && (32'(i_elem_b) <= 32'(MAX_ELEMENTS));

        unique case (ctrl.cond)
            ufse_pkg::C_ALWAYS:    take = 1'b1;
            ufse_pkg::C_CLR_MORE:  take = (r_clr != AW'(MAX_ELEMENTS));
            ufse_pkg::C_IDLE_STAY: take = !(start && a_ok && b_ok);
            ufse_pkg::C_NOT_ROOT:  take = !is_root;
            ufse_pkg::C_FINISH:    take = is_query || (r_root_a == r_root_b);
            ufse_pkg::C_NO_BUMP:   take = (r_rank_a != r_rank_b)
                || (r_rank_b == ufse_pkg::RANK_TOP);
            default:               take = 1'b1;
        endcase

        n_pc = take ? ctrl.target : ufse_pkg::t_step'(3'(r_pc) + 3'd1);

        n_clr    = r_clr;
        n_cur    = r_cur;
        n_elem_b = r_elem_b;
        n_op     = r_op;
        n_root_a = r_root_a;
        n_root_b = r_root_b;
        n_rank_a = r_rank_a;
        n_rank_b = r_rank_b;

        if (ctrl.load && start) begin
            n_cur    = AW'(i_elem_a);
            n_elem_b = AW'(i_elem_b);
            n_op     = i_op;
        end

        if (ctrl.walk) begin
            if (is_root) begin
                if (ctrl.root_b) begin
                    n_root_b = r_cur;
                    n_rank_b = rank;
                end else begin
                    n_root_a = r_cur;
                    n_rank_a = rank;
                end
                n_cur = r_elem_b;
            end else begin
                n_cur = parent;
            end
        end

        we      = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        unique case (ctrl.wr)
            ufse_pkg::WR_NONE: begin
                we = 1'b0;
            end
            ufse_pkg::WR_CLEAR: begin
                we    = 1'b1;
                n_clr = r_clr + AW'(1);
            end
            ufse_pkg::WR_LINK: begin
                we = 1'b1;
                if (r_rank_a > r_rank_b) begin
                    wr_addr = r_root_b;
                    wr_data = {r_rank_b, r_root_a};
                end else begin
                    wr_addr = r_root_a;
                    wr_data = {r_rank_a, r_root_b};
                end
            end
            ufse_pkg::WR_BUMP: begin
                we      = 1'b1;
                wr_addr = r_root_b;
                wr_data = {r_rank_b + RW'(1), AW'(0)};
            end
            default: begin
                we = 1'b0;
            end
        endcase

        n_valid = ctrl.emit && is_query;
        n_same  = (r_root_a == r_root_b);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_word <= mem[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ufse_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_set_count <= ufse_pkg::SET_COUNT_RESET;
            r_valid     <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_set_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_elem_b <= n_elem_b;
        r_op     <= n_op;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_rank_a <= n_rank_a;
        r_rank_b <= n_rank_b;
        r_same   <= n_same;
    end

    assign busy           = (r_pc != ufse_pkg::ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_same_set     = r_same;

    `ASSERT_SAME_CYCLE(a_result_from_query, o_result_valid, $past(ctrl.emit && is_query))
    `ASSERT_NEXT_CYCLE(a_accept_walks, start && !busy && a_ok && b_ok, r_pc == ufse_pkg::ST_WALK_A)
    `ASSERT_SAME_CYCLE(a_no_self_link, r_pc == ufse_pkg::ST_LINK, r_root_a != r_root_b && !is_query)

endmodule
